// ===== hdl/ntt_polynomial_multiply_assert.svh =====
// Assertion macros used by the polynomial multiplier checker.
`ifndef NTT_POLYNOMIAL_MULTIPLY_ASSERT_SVH
`define NTT_POLYNOMIAL_MULTIPLY_ASSERT_SVH

// Property must hold at every edge outside reset.
`define NPM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Expression must never be true outside reset.
`define NPM_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

// ===== hdl/npm_pkg.sv =====
// Types and constants of the polynomial multiplier.
package npm_pkg;

    localparam int unsigned COEF_W  = 30;
    localparam int unsigned INDEX_W = 10;
    localparam int unsigned LEN_W   = 10;
    localparam logic [COEF_W:0] PRIME = 31'd998244353;

    typedef enum logic [1:0] {
        REQ_LOAD_F  = 2'd0,
        REQ_LOAD_G  = 2'd1,
        REQ_COMPUTE = 2'd2,
        REQ_READ    = 2'd3
    } t_req;

    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [1:0] {
        REG_F_LENGTH      = 2'd0,
        REG_G_LENGTH      = 2'd1,
        REG_RESULT_LENGTH = 2'd2,
        REG_NONE          = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_START,
        S_ADDR,
        S_FETCH,
        S_MUL,
        S_ACC,
        S_DONE
    } t_state;

endpackage

// ===== hdl/npm_if.sv =====
// Request and response channel interfaces.
interface npm_req_if import npm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_req                 req_type;
    logic [INDEX_W-1:0]   coef_index;
    logic [COEF_W-1:0]    coef_value;

    modport source (output valid, req_type, coef_index, coef_value, input ready);
    modport sink   (input valid, req_type, coef_index, coef_value, output ready);
endinterface

interface npm_rsp_if import npm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 result_kind;
    logic [COEF_W-1:0]    result_value;

    modport source (output valid, result_kind, result_value, input ready);
    modport sink   (input valid, result_kind, result_value, output ready);
endinterface

// ===== hdl/npm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module npm_ram #(
    parameter int unsigned WIDTH = 30,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule

// ===== hdl/ntt_polynomial_multiply.sv =====
// Polynomial product modulo 998244353 with one shared modular multiplier.
//
//  channel  dir  handshake             payload
//  i_req    in   valid/ready           req_type, coef_index, coef_value
//  o_rsp    out  valid/ready           result_kind, result_value
//  apb      in   psel/penable/pwrite   paddr, pwdata (prdata back)
//
// A load writes its operand store; a read goes via S_READ to the response register.
// Compute takes each coefficient pair through S_ADDR and S_FETCH, a bit-serial
// modular multiply in S_MUL, and S_ACC, which adds the product into the term.
// Reset is synchronous, active low; operand stores are not cleared.
// A waiting response holds off new requests until it is taken.
module ntt_polynomial_multiply import npm_pkg::*; #(
    parameter int unsigned MAX_POINTS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    npm_req_if.sink     i_req,
    npm_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int unsigned AW   = $clog2(MAX_POINTS);
    localparam int unsigned CW   = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
    localparam int unsigned HALF = MAX_POINTS / 2;
    localparam int unsigned MW   = $clog2(COEF_W);

    t_state r_state, n_state;
    logic [LEN_W-1:0]  r_f_length, r_g_length, r_result_length;
    logic [AW-1:0]     r_fl, r_gl, r_keep, r_kept, r_k, r_i, r_i_hi;
    logic [AW-1:0]     n_fl, n_gl, n_keep, n_kept, n_k, n_i, n_i_hi;
    logic [COEF_W-1:0] r_a, r_b, r_r, r_acc, n_a, n_b, n_r, n_acc;
    logic [MW-1:0]     r_cnt, n_cnt;
    logic              r_rd_hit, n_rd_hit;
    logic              r_out_valid, n_out_valid, r_out_kind, n_out_kind;
    logic [COEF_W-1:0] r_out_value, n_out_value;

    logic              accept, cfg_wr;
    t_reg_idx          cfg_idx;
    logic [CW-1:0]     fl_c, gl_c;
    logic [AW-1:0]     full_len, keep_len, i_lo, i_hi;
    logic [COEF_W:0]   dbl, dbl_red, sum, sum_red, acc_sum, acc_red;
    logic              in_range;
    logic              f_we, g_we, p_we;
    logic [AW-1:0]     st_addr, p_rd_addr;
    logic [COEF_W-1:0] st_val, f_q, g_q, p_q;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_comb begin
        case (cfg_idx)
            REG_F_LENGTH:      prdata = 32'(r_f_length);
            REG_G_LENGTH:      prdata = 32'(r_g_length);
            REG_RESULT_LENGTH: prdata = 32'(r_result_length);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_length      <= LEN_W'(1);
            r_g_length      <= LEN_W'(1);
            r_result_length <= LEN_W'(1);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_F_LENGTH:      r_f_length      <= pwdata[LEN_W-1:0];
                REG_G_LENGTH:      r_g_length      <= pwdata[LEN_W-1:0];
                REG_RESULT_LENGTH: r_result_length <= pwdata[LEN_W-1:0];
                default:           ;
            endcase
        end
    end

    // Clamp lengths to [1, MAX_POINTS/2] and size the product.
    always_comb begin
        if (r_f_length == '0)                  fl_c = CW'(1);
        else if (CW'(r_f_length) > CW'(HALF))  fl_c = CW'(HALF);
        else                                   fl_c = CW'(r_f_length);
        if (r_g_length == '0)                  gl_c = CW'(1);
        else if (CW'(r_g_length) > CW'(HALF))  gl_c = CW'(HALF);
        else                                   gl_c = CW'(r_g_length);
        full_len = AW'(fl_c + gl_c - CW'(1));
        keep_len = (CW'(r_result_length) < CW'(full_len)) ?
                   AW'(r_result_length) : full_len;
    end

    // Index window of the first operand for output term r_k.
    assign i_lo = (r_k >= r_gl) ? AW'(r_k - r_gl + AW'(1)) : '0;
    assign i_hi = (r_k < AW'(r_fl - AW'(1))) ? r_k : AW'(r_fl - AW'(1));

    // Shared unit: one double-and-add step of the modular multiply, and the modular add into the accumulator.
    always_comb begin
        dbl     = {r_r, 1'b0};
        dbl_red = (dbl >= PRIME) ? dbl - PRIME : dbl;
        sum     = dbl_red + (r_b[COEF_W-1] ? {1'b0, r_a} : '0);
        sum_red = (sum >= PRIME) ? sum - PRIME : sum;
        acc_sum = {1'b0, r_acc} + {1'b0, r_r};
        acc_red = (acc_sum >= PRIME) ? acc_sum - PRIME : acc_sum;
    end

    assign accept   = i_req.valid && i_req.ready;
    assign in_range = CW'(i_req.coef_index) < CW'(MAX_POINTS);
    assign st_addr  = AW'(i_req.coef_index);
    assign st_val   = ({1'b0, i_req.coef_value} >= PRIME) ?
                      COEF_W'({1'b0, i_req.coef_value} - PRIME) : i_req.coef_value;
    assign f_we     = accept && (i_req.req_type == REQ_LOAD_F) && in_range;
    assign g_we     = accept && (i_req.req_type == REQ_LOAD_G) && in_range;
    assign p_we     = (r_state == S_ACC) && (r_i == r_i_hi);
    assign p_rd_addr = AW'(i_req.coef_index);

    npm_ram #(.WIDTH(COEF_W), .DEPTH(MAX_POINTS)) u_f_ram (
        .i_clk, .i_wr_en(f_we), .i_wr_addr(st_addr), .i_wr_data(st_val),
        .i_rd_addr(r_i), .o_rd_data(f_q)
    );
    npm_ram #(.WIDTH(COEF_W), .DEPTH(MAX_POINTS)) u_g_ram (
        .i_clk, .i_wr_en(g_we), .i_wr_addr(st_addr), .i_wr_data(st_val),
        .i_rd_addr(AW'(r_k - r_i)), .o_rd_data(g_q)
    );
    npm_ram #(.WIDTH(COEF_W), .DEPTH(MAX_POINTS)) u_p_ram (
        .i_clk, .i_wr_en(p_we), .i_wr_addr(r_k), .i_wr_data(COEF_W'(acc_red)),
        .i_rd_addr(p_rd_addr), .o_rd_data(p_q)
    );

    assign i_req.ready        = (r_state == S_IDLE) && !r_out_valid;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_kind  = r_out_kind;
    assign o_rsp.result_value = r_out_value;

    always_comb begin
        n_state     = r_state;
        n_fl        = r_fl;
        n_gl        = r_gl;
        n_keep      = r_keep;
        n_kept      = r_kept;
        n_k         = r_k;
        n_i         = r_i;
        n_i_hi      = r_i_hi;
        n_a         = r_a;
        n_b         = r_b;
        n_r         = r_r;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_rd_hit    = r_rd_hit;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_kind  = r_out_kind;
        n_out_value = r_out_value;
        case (r_state)
            S_IDLE: begin
                if (accept && i_req.req_type == REQ_READ) begin
                    n_rd_hit = CW'(i_req.coef_index) < CW'(r_kept);
                    n_state  = S_READ;
                end else if (accept && i_req.req_type == REQ_COMPUTE) begin
                    n_fl    = AW'(fl_c);
                    n_gl    = AW'(gl_c);
                    n_keep  = keep_len;
                    n_k     = '0;
                    n_state = S_START;
                end
            end
            S_READ: begin
                n_out_valid = 1'b1;
                n_out_kind  = KIND_READ;
                n_out_value = r_rd_hit ? p_q : '0;
                n_state     = S_IDLE;
            end
            S_START: begin
                if (r_keep == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = i_lo;
                    n_i_hi  = i_hi;
                    n_acc   = '0;
                    n_state = S_ADDR;
                end
            end
            S_ADDR: n_state = S_FETCH;
            S_FETCH: begin
                n_a     = f_q;
                n_b     = g_q;
                n_r     = '0;
                n_cnt   = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_r   = COEF_W'(sum_red);
                n_b   = {r_b[COEF_W-2:0], 1'b0};
                n_cnt = MW'(r_cnt + MW'(1));
                if (r_cnt == MW'(COEF_W - 1)) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_acc = COEF_W'(acc_red);
                if (r_i == r_i_hi) begin
                    // term complete: advance to the next output term, or finish after the last
                    if (r_k == AW'(r_keep - AW'(1))) begin
                        n_state = S_DONE;
                    end else begin
                        n_k     = AW'(r_k + AW'(1));
                        n_state = S_START;
                    end
                end else begin
                    n_i     = AW'(r_i + AW'(1));
                    n_state = S_ADDR;
                end
            end
            S_DONE: begin
                n_kept      = r_keep;
                n_out_valid = 1'b1;
                n_out_kind  = KIND_DONE;
                n_out_value = '0;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kept      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kept      <= n_kept;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fl        <= n_fl;
        r_gl        <= n_gl;
        r_keep      <= n_keep;
        r_k         <= n_k;
        r_i         <= n_i;
        r_i_hi      <= n_i_hi;
        r_a         <= n_a;
        r_b         <= n_b;
        r_r         <= n_r;
        r_acc       <= n_acc;
        r_cnt       <= n_cnt;
        r_rd_hit    <= n_rd_hit;
        r_out_kind  <= n_out_kind;
        r_out_value <= n_out_value;
    end
endmodule

// ===== hdl/npm_checker.sv =====
// Port-level checker for the polynomial multiplier, bound to the top level.
`include "ntt_polynomial_multiply_assert.svh"

module npm_checker import npm_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input t_req        i_req_type,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic        i_pready
);
    logic req_beat;
    assign req_beat = i_req_valid && i_req_ready;

    `NPM_ASSERT_NEVER(a_ready_with_pending, i_clk, i_rst_n, i_req_ready && i_rsp_valid, "request ready while response waits")
    `NPM_ASSERT(a_read_two_cycles, i_clk, i_rst_n, req_beat && i_req_type == REQ_READ |-> ##2 i_rsp_valid, "read response late")
    `NPM_ASSERT(a_compute_busy, i_clk, i_rst_n, req_beat && i_req_type == REQ_COMPUTE |=> !i_req_ready, "ready during compute")
    `NPM_ASSERT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid, "response dropped")
    `NPM_ASSERT(a_pready, i_clk, i_rst_n, i_pready, "pready low")
endmodule

bind ntt_polynomial_multiply npm_checker u_npm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_type  (i_req.req_type),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_pready    (pready)
);

// ===== verif/ntt_polynomial_multiply_tb.sv =====
// Testbench for the polynomial multiplier: random loads, computes and reads against a predictor.
module ntt_polynomial_multiply_tb;
    import npm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          POINTS    = 1024;
    localparam int          HALF      = POINTS / 2;
    localparam int          WDOG_MAX  = 500000;
    localparam logic [29:0] P_MINUS_1 = 30'd998244352;

    typedef struct packed {
        t_req               req;
        logic [INDEX_W-1:0] idx;
        logic [COEF_W-1:0]  val;
    } t_item;

    typedef struct packed {
        logic              kind;
        logic [COEF_W-1:0] value;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic pready;

    npm_req_if req_ch ();
    npm_rsp_if rsp_ch ();

    ntt_polynomial_multiply u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    t_item   req_pending[$];
    t_result result_expected[$];
    int      mismatch_cnt = 0;
    int      idle_cycles = 0;
    logic    req_taken = 1'b0;
    int      req_gap = 0;
    int      rsp_stall = 0;

    // predictor state
    logic [9:0]        f_len_reg, g_len_reg, r_len_reg;
    logic [COEF_W-1:0] f_coef[POINTS];
    logic [COEF_W-1:0] g_coef[POINTS];
    logic [COEF_W-1:0] prod_coef[POINTS];
    int                kept_len;

    // stimulus bookkeeping: which operand entries hold a loaded value
    bit f_loaded[POINTS];
    bit g_loaded[POINTS];

    function automatic int clamp_len(input logic [9:0] v);
        if (v == 0) return 1;
        if (v > HALF) return HALF;
        return int'(v);
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return P_MINUS_1;
        if (r == 2) return '1;
        return COEF_W'($urandom());
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_cnt++;
    endtask

    task automatic form_product();
        int fl, gl, full, keep;
        logic [63:0] acc;
        fl = clamp_len(f_len_reg);
        gl = clamp_len(g_len_reg);
        full = fl + gl - 1;
        keep = (int'(r_len_reg) < full) ? int'(r_len_reg) : full;
        foreach (prod_coef[k]) prod_coef[k] = '0;
        for (int k = 0; k < keep; k++) begin
            acc = 0;
            for (int i = 0; i < fl && i <= k; i++) begin
                if (k - i < gl) begin
                    acc = (acc + (64'(f_coef[i]) * 64'(g_coef[k - i])) % 64'(PRIME))
                          % 64'(PRIME);
                end
            end
            prod_coef[k] = acc[COEF_W-1:0];
        end
        kept_len = keep;
    endtask

    task automatic predict(input t_item it);
        logic [COEF_W-1:0] red;
        red = (it.val >= PRIME) ? COEF_W'(31'(it.val) - PRIME) : it.val;
        case (it.req)
            REQ_LOAD_F: f_coef[it.idx] = red;
            REQ_LOAD_G: g_coef[it.idx] = red;
            REQ_COMPUTE: begin
                form_product();
                result_expected.push_back('{KIND_DONE, '0});
            end
            default: begin
                result_expected.push_back('{KIND_READ,
                    (int'(it.idx) < kept_len) ? prod_coef[it.idx] : '0});
            end
        endcase
    endtask

    // monitor: both channels sampled at the rising edge
    always @(posedge i_clk) begin
        t_result want;
        req_taken <= i_rst_n && req_ch.valid && req_ch.ready;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (result_expected.size() == 0) begin
                    report("unexpected beat", rsp_ch.result_value, 0);
                end else begin
                    want = result_expected.pop_front();
                    if (rsp_ch.result_kind !== want.kind)
                        report("result_kind", rsp_ch.result_kind, want.kind);
                    if (rsp_ch.result_value !== want.value)
                        report("result_value", rsp_ch.result_value, want.value);
                end
            end
            if (req_ch.valid && req_ch.ready)
                predict('{req_ch.req_type, req_ch.coef_index, req_ch.coef_value});
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        t_item it;
        if (i_rst_n && (!req_ch.valid || req_taken)) begin
            if (req_gap > 0) begin
                req_ch.valid <= 1'b0;
                req_gap <= req_gap - 1;
            end else if (req_pending.size() > 0) begin
                it = req_pending.pop_front();
                req_ch.valid      <= 1'b1;
                req_ch.req_type   <= it.req;
                req_ch.coef_index <= it.idx;
                req_ch.coef_value <= it.val;
                req_gap <= gap_len();
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // response back-pressure
    always @(negedge i_clk) begin
        if (rsp_stall > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall <= rsp_stall - 1;
        end else if ($urandom_range(7) == 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall <= gap_len();
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    task automatic reg_write(input t_reg_idx r, input logic [9:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(r) << 2;
        pwdata  <= 32'(v);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (r)
            REG_F_LENGTH: f_len_reg = v;
            REG_G_LENGTH: g_len_reg = v;
            default:      r_len_reg = v;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        while (req_pending.size() > 0 || req_ch.valid || result_expected.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic push_item(input t_req rq, input int idx, input logic [COEF_W-1:0] v);
        req_pending.push_back('{rq, INDEX_W'(idx), v});
        if (rq == REQ_LOAD_F) f_loaded[idx] = 1'b1;
        if (rq == REQ_LOAD_G) g_loaded[idx] = 1'b1;
    endtask

    // fill every operand entry that a compute at the current lengths will use
    task automatic push_compute();
        for (int i = 0; i < clamp_len(f_len_reg); i++)
            if (!f_loaded[i]) push_item(REQ_LOAD_F, i, rand_coef());
        for (int i = 0; i < clamp_len(g_len_reg); i++)
            if (!g_loaded[i]) push_item(REQ_LOAD_G, i, rand_coef());
        push_item(REQ_COMPUTE, $urandom_range(1023), COEF_W'($urandom()));
    endtask

    task automatic run_phase(input logic [9:0] fl, input logic [9:0] gl, input logic [9:0] rl,
                             input int count, input int ncomp);
        int span, r, nxt;
        wait_drained();
        reg_write(REG_F_LENGTH, fl);
        reg_write(REG_G_LENGTH, gl);
        reg_write(REG_RESULT_LENGTH, rl);
        span = clamp_len(fl) + clamp_len(gl) + 2;
        nxt = 1;
        for (int i = 0; i < count; i++) begin
            if (nxt <= ncomp && i == count * nxt / (ncomp + 1)) begin
                push_compute();
                nxt++;
            end
            r = $urandom_range(99);
            if (r < 30)
                push_item(REQ_LOAD_F, ($urandom_range(3) == 0) ? $urandom_range(1023)
                          : $urandom_range(clamp_len(fl) + 1), rand_coef());
            else if (r < 60)
                push_item(REQ_LOAD_G, ($urandom_range(3) == 0) ? $urandom_range(1023)
                          : $urandom_range(clamp_len(gl) + 1), rand_coef());
            else
                push_item(REQ_READ, ($urandom_range(4) == 0) ? $urandom_range(1023)
                          : $urandom_range(span), COEF_W'($urandom()));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_LOAD_F;
        req_ch.coef_index = '0;
        req_ch.coef_value = '0;
        rsp_ch.ready = 1'b0;
        f_len_reg = 10'd1;
        g_len_reg = 10'd1;
        r_len_reg = 10'd1;
        kept_len = 0;
        foreach (f_coef[i]) begin
            f_coef[i] = '0;
            g_coef[i] = '0;
            prod_coef[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reads before any compute, extreme and unreduced values
        push_item(REQ_READ, 0, '0);
        push_item(REQ_READ, 1023, '1);
        push_item(REQ_LOAD_F, 0, P_MINUS_1);
        push_item(REQ_LOAD_G, 0, '1);
        push_item(REQ_LOAD_F, 1023, '0);
        push_item(REQ_LOAD_G, 1023, PRIME[COEF_W-1:0]);
        push_item(REQ_COMPUTE, 0, '0);
        push_item(REQ_READ, 0, '0);
        push_item(REQ_READ, 1, '0);
        push_item(REQ_READ, 1023, '0);

        // zero lengths act as one, zero result length keeps nothing
        run_phase(10'd0, 10'd0, 10'd0, 20, 1);
        // lengths at and beyond the upper limit
        run_phase(10'd512, 10'd2, 10'd1023, 60, 1);
        run_phase(10'd3, 10'd1023, 10'd1023, 60, 1);
        // new lengths must not disturb reads of the last product
        wait_drained();
        reg_write(REG_RESULT_LENGTH, 10'd2);
        for (int i = 0; i < 8; i++) push_item(REQ_READ, $urandom_range(520), '0);
        run_phase(10'd1023, 10'd1, 10'd700, 60, 1);
        run_phase(10'd2, 10'd512, 10'd5, 40, 1);
        for (int p = 0; p < 9; p++)
            run_phase(10'($urandom_range(12, 1)), 10'($urandom_range(12, 1)),
                      ($urandom_range(5) == 0) ? 10'd0 : 10'($urandom_range(30, 1)),
                      45, 3);
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/npm_pkg.sv
hdl/npm_if.sv
hdl/npm_ram.sv
hdl/ntt_polynomial_multiply.sv
hdl/npm_checker.sv
verif/ntt_polynomial_multiply_tb.sv
